@@ rtl/core/jvff_pkg.sv @@
// ----------------------------------------------------------------------------
// jvff_pkg
// Shared types and constants of the joint velocity controller with timeout
// hold: beat payloads, status and register index codes.
// ----------------------------------------------------------------------------
package jvff_pkg;

  localparam int unsigned JointW  = 2;
  localparam int unsigned PosW    = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned GainsW  = 64;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic {
    REQ_CMD = 1'b0,
    REQ_UPD = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DRIVE  = 2'd0,
    ST_STAGED = 2'd1,
    ST_COMMIT = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NORMAL_GAINS = 1'b0,
    CFG_SAFE_GAINS   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e                     req_type;
    logic [JointW-1:0]        joint;
    logic signed [PosW-1:0]   position;
    logic signed [PosW-1:0]   ff_velocity;
    logic signed [TickW-1:0]  timeout_ticks;
    logic [TickW-1:0]         elapsed_ticks;
    logic                     last;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [JointW-1:0]        joint_out;
    logic signed [PosW-1:0]   drive_velocity;
    logic                     holding;
  } rsp_t;

endpackage

@@ rtl/core/jvff_if.sv @@
// ----------------------------------------------------------------------------
// jvff channel interfaces
// Valid/ready channels for request beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface jvff_req_if;
  logic           valid;
  logic           ready;
  jvff_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jvff_rsp_if;
  logic           valid;
  logic           ready;
  jvff_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jvff_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jvff_pkg::CfgIdxW-1:0]       index;
  logic [jvff_pkg::GainsW-1:0]        wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/joint_velocity_ff_with_timeout_hold.sv @@
// ----------------------------------------------------------------------------
// joint_velocity_ff_with_timeout_hold
// Multi-joint position controller with velocity feed-forward, staged group
// commands and a timeout that falls back to holding position.
// A request beat goes through the input register, then the result register.
// Throughput: one beat per cycle while results are taken; all joint state is
// read and updated in the single compute stage between the two registers.
// Reset: targets, held positions, stopwatch and flags clear; active timeout
// is zero (immediate hold); gains clear; staged entries are not reset.
// ----------------------------------------------------------------------------
module joint_velocity_ff_with_timeout_hold #(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jvff_req_if.sink     req_i,
  jvff_rsp_if.source   rsp_o,
  jvff_cfg_if.sink     cfg_i
);

  localparam int unsigned IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned PosW = jvff_pkg::PosW;

  // gain registers
  logic [jvff_pkg::GainsW-1:0] normal_gains_q, safe_gains_q;

  // joint state
  logic signed [PosW-1:0] tgt_pos_q [NUM_JOINTS];
  logic signed [PosW-1:0] tgt_vel_q [NUM_JOINTS];
  logic signed [PosW-1:0] held_q    [NUM_JOINTS];
  logic signed [PosW-1:0] stg_pos_q [NUM_JOINTS];
  logic signed [PosW-1:0] stg_vel_q [NUM_JOINTS];
  logic signed [jvff_pkg::TickW-1:0] stg_tmo_q, act_tmo_q;
  logic [NUM_JOINTS-1:0]             mask_q;
  logic [jvff_pkg::TickW-1:0]        sw_q;
  logic                              was_hold_q, tnow_q;

  // pipeline
  logic           s1_valid;
  jvff_pkg::req_t d;
  logic           adv;
  logic           rsp_valid_q;
  jvff_pkg::rsp_t rsp_q, rsp_d;

  jvff_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_data_i  (req_i.data),
    .in_ready_o (req_i.ready),
    .take_i     (adv),
    .valid_o    (s1_valid),
    .data_o     (d)
  );

  assign adv = s1_valid && (!rsp_valid_q || rsp_o.ready);

  // decode
  logic                  is_cmd, is_upd, jv, upd0, full, commit;
  logic [IdxW-1:0]       jidx;
  logic [NUM_JOINTS-1:0] mask_set, mask_new;
  logic [jvff_pkg::TickW:0]   sw_sum;
  logic [jvff_pkg::TickW-1:0] sw_sat;
  logic                  act_pos, t_new, tn;
  logic signed [PosW-1:0] held_val, ref_pos, ff_sel, calc_drive;
  logic [jvff_pkg::GainW-1:0] gain_sel;

  assign is_cmd   = d.req_type == jvff_pkg::REQ_CMD;
  assign is_upd   = d.req_type == jvff_pkg::REQ_UPD;
  assign jv       = {1'b0, d.joint} < (jvff_pkg::JointW + 1)'(NUM_JOINTS);
  assign jidx     = IdxW'(d.joint);
  assign upd0     = is_upd && jv && (d.joint == '0);
  assign mask_set = jv ? (NUM_JOINTS'(1) << jidx) : '0;
  assign mask_new = mask_q | mask_set;
  assign full     = &mask_new;
  assign commit   = is_cmd && d.last && full;

  assign sw_sum  = {1'b0, sw_q} + {1'b0, d.elapsed_ticks};
  assign sw_sat  = sw_sum[jvff_pkg::TickW] ? '1 : sw_sum[jvff_pkg::TickW-1:0];
  assign act_pos = !act_tmo_q[jvff_pkg::TickW-1] && (act_tmo_q != '0);
  assign t_new   = act_pos ? (sw_sat > act_tmo_q[jvff_pkg::TickW-1:0])
                           : (act_tmo_q == '0);
  assign tn      = upd0 ? t_new : tnow_q;

  assign held_val = was_hold_q ? held_q[jidx] : d.position;
  assign ref_pos  = tn ? held_val : tgt_pos_q[jidx];
  assign ff_sel   = tn ? '0 : tgt_vel_q[jidx];
  assign gain_sel = tn ? safe_gains_q[{d.joint, 4'b0000} +: jvff_pkg::GainW]
                       : normal_gains_q[{d.joint, 4'b0000} +: jvff_pkg::GainW];

  jvff_drive_calc u_drive_calc (
    .ref_pos_i  (ref_pos),
    .meas_pos_i (d.position),
    .gain_i     (gain_sel),
    .ff_i       (ff_sel),
    .drive_o    (calc_drive)
  );

  always_comb begin
    rsp_d.joint_out      = d.joint;
    rsp_d.drive_velocity = '0;
    rsp_d.holding        = 1'b0;
    if (is_cmd) begin
      if (!d.last) begin
        rsp_d.status = jvff_pkg::ST_STAGED;
      end else if (full) begin
        rsp_d.status = jvff_pkg::ST_COMMIT;
      end else begin
        rsp_d.status = jvff_pkg::ST_REJECT;
      end
    end else begin
      rsp_d.status  = jvff_pkg::ST_DRIVE;
      rsp_d.holding = tn;
      if (jv) begin
        rsp_d.drive_velocity = calc_drive;
      end
    end
  end

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gains_q <= '0;
      safe_gains_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        jvff_pkg::CFG_NORMAL_GAINS: normal_gains_q <= cfg_i.wdata;
        jvff_pkg::CFG_SAFE_GAINS:   safe_gains_q   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // staged entries
  always_ff @(posedge clk_i) begin
    if (adv && is_cmd && jv) begin
      stg_pos_q[jidx] <= d.position;
      stg_vel_q[jidx] <= d.ff_velocity;
      stg_tmo_q       <= d.timeout_ticks;
    end
  end

  // committed and tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        tgt_pos_q[i] <= '0;
        tgt_vel_q[i] <= '0;
        held_q[i]    <= '0;
      end
      act_tmo_q  <= '0;
      mask_q     <= '0;
      sw_q       <= '0;
      was_hold_q <= 1'b0;
      tnow_q     <= 1'b0;
    end else if (adv) begin
      if (is_cmd) begin
        mask_q <= d.last ? '0 : mask_new;
        if (commit) begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            if (jv && (jidx == IdxW'(i))) begin
              tgt_pos_q[i] <= d.position;
              tgt_vel_q[i] <= d.ff_velocity;
            end else begin
              tgt_pos_q[i] <= stg_pos_q[i];
              tgt_vel_q[i] <= stg_vel_q[i];
            end
          end
          act_tmo_q <= jv ? d.timeout_ticks : stg_tmo_q;
          sw_q      <= '0;
        end
      end else begin
        if (upd0) begin
          tnow_q <= t_new;
          if (act_pos) begin
            sw_q <= sw_sat;
          end
        end
        if (jv && !was_hold_q) begin
          held_q[jidx] <= d.position;
        end
        if (d.last) begin
          was_hold_q <= tn;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // checks
  a_nondrive_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status != jvff_pkg::ST_DRIVE))
      |-> (rsp_q.drive_velocity == '0) && !rsp_q.holding)
    else $error("non-drive result carries drive or hold");

  a_commit_clears_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && commit) |=> (sw_q == '0))
    else $error("stopwatch not cleared on commit");

  a_last_clears_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_cmd && d.last) |=> (mask_q == '0))
    else $error("staged mask not cleared at group end");

  a_zero_tmo_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && upd0 && (act_tmo_q == '0)) |=> tnow_q)
    else $error("zero timeout did not hold");

endmodule

@@ rtl/core/jvff_in_reg.sv @@
// ----------------------------------------------------------------------------
// jvff_in_reg
// Input register stage: captures one request beat and holds it until the
// compute stage takes it.
// ----------------------------------------------------------------------------
module jvff_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  jvff_pkg::req_t in_data_i,
  output logic           in_ready_o,
  input  logic           take_i,
  output logic           valid_o,
  output jvff_pkg::req_t data_o
);

  logic           valid_q, valid_d;
  jvff_pkg::req_t data_q;
  logic           fire;

  assign in_ready_o = !valid_q || take_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/jvff_drive_calc.sv @@
// ----------------------------------------------------------------------------
// jvff_drive_calc
// Drive arithmetic: gain times position error, floor shift by eight,
// feed-forward add and saturation to Q16.16.
// ----------------------------------------------------------------------------
module jvff_drive_calc (
  input  logic signed [jvff_pkg::PosW-1:0] ref_pos_i,
  input  logic signed [jvff_pkg::PosW-1:0] meas_pos_i,
  input  logic [jvff_pkg::GainW-1:0]       gain_i,
  input  logic signed [jvff_pkg::PosW-1:0] ff_i,
  output logic signed [jvff_pkg::PosW-1:0] drive_o
);

  localparam int unsigned ErrW  = jvff_pkg::PosW + 1;
  localparam int unsigned ProdW = ErrW + jvff_pkg::GainW + 1;
  localparam int unsigned ScW   = ProdW - 8;
  localparam int unsigned SumW  = ScW + 1;

  logic signed [ErrW-1:0]  err;
  logic signed [ProdW-1:0] prod;
  logic signed [ScW-1:0]   scaled;
  logic signed [SumW-1:0]  sum;
  logic                    in_range;

  assign err    = {ref_pos_i[jvff_pkg::PosW-1], ref_pos_i}
                - {meas_pos_i[jvff_pkg::PosW-1], meas_pos_i};
  assign prod   = err * $signed({1'b0, gain_i});
  // arithmetic shift rounds toward minus infinity
  assign scaled = prod[ProdW-1:8];
  assign sum    = {scaled[ScW-1], scaled}
                + {{(SumW - jvff_pkg::PosW){ff_i[jvff_pkg::PosW-1]}}, ff_i};

  assign in_range = (&sum[SumW-1:jvff_pkg::PosW-1]) || !(|sum[SumW-1:jvff_pkg::PosW-1]);

  always_comb begin
    if (in_range) begin
      drive_o = sum[jvff_pkg::PosW-1:0];
    end else if (sum[SumW-1]) begin
      drive_o = {1'b1, {(jvff_pkg::PosW-1){1'b0}}};
    end else begin
      drive_o = {1'b0, {(jvff_pkg::PosW-1){1'b1}}};
    end
  end

endmodule

@@ tb/sv/jvff_drive_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvff_drive_checker
// Watches the request, result and register write channels of the joint
// velocity controller, keeps its own copy of the controller state, predicts
// one result beat for every accepted request beat and compares each accepted
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jvff_drive_checker #(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jvff_req_if         req_i,
  jvff_rsp_if         rsp_i,
  jvff_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam longint DriveMax = 64'sd2147483647;
  localparam longint DriveMin = -64'sd2147483648;

  logic [jvff_pkg::GainsW-1:0]    normal_gains;
  logic [jvff_pkg::GainsW-1:0]    safe_gains;
  logic signed [jvff_pkg::PosW-1:0] target_pos [NUM_JOINTS];
  logic signed [jvff_pkg::PosW-1:0] target_vel [NUM_JOINTS];
  logic signed [jvff_pkg::PosW-1:0] staged_pos [NUM_JOINTS];
  logic signed [jvff_pkg::PosW-1:0] staged_vel [NUM_JOINTS];
  logic signed [jvff_pkg::PosW-1:0] held_pos   [NUM_JOINTS];
  logic signed [jvff_pkg::TickW-1:0] active_timeout;
  logic signed [jvff_pkg::TickW-1:0] staged_timeout;
  logic [3:0]                     staged_mask;
  logic [jvff_pkg::TickW-1:0]     stopwatch;
  logic                           was_holding;
  logic                           timeout_now;

  jvff_pkg::rsp_t pending_drive_beats [$];
  jvff_pkg::rsp_t want;
  jvff_pkg::rsp_t got;
  int unsigned    fail_count = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic jvff_pkg::rsp_t next_drive_beat(input jvff_pkg::req_t b);
    jvff_pkg::rsp_t r;
    int unsigned    j;
    longint         meas;
    longint         err;
    longint         gain;
    longint         acc;
    longint         sw;
    longint         lim;
    logic [32:0]    sum;
    logic [3:0]     full;
    full = 4'((1 << NUM_JOINTS) - 1);
    j = 32'(b.joint);
    meas = $signed(b.position);
    r.status = jvff_pkg::ST_DRIVE;
    r.joint_out = b.joint;
    r.drive_velocity = '0;
    r.holding = 1'b0;
    if (b.req_type == jvff_pkg::REQ_CMD) begin
      if (j < NUM_JOINTS) begin
        staged_pos[j] = b.position;
        staged_vel[j] = b.ff_velocity;
        staged_timeout = b.timeout_ticks;
        staged_mask[j] = 1'b1;
      end
      r.status = jvff_pkg::ST_STAGED;
      if (b.last) begin
        if ((staged_mask & full) == full) begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            target_pos[i] = staged_pos[i];
            target_vel[i] = staged_vel[i];
          end
          active_timeout = staged_timeout;
          stopwatch = '0;
          r.status = jvff_pkg::ST_COMMIT;
        end else begin
          r.status = jvff_pkg::ST_REJECT;
        end
        staged_mask = '0;
      end
    end else begin
      if (j < NUM_JOINTS) begin
        if (j == 0) begin
          timeout_now = (active_timeout == 0);
          if (active_timeout > 0) begin
            sum = {1'b0, stopwatch} + {1'b0, b.elapsed_ticks};
            stopwatch = sum[32] ? '1 : sum[31:0];
            sw = longint'({32'd0, stopwatch});
            lim = longint'(active_timeout);
            timeout_now = sw > lim;
          end
        end
        if (!was_holding) held_pos[j] = b.position;
        if (timeout_now) begin
          err = longint'(held_pos[j]) - meas;
          gain = longint'({48'd0, safe_gains[16*j +: 16]});
          acc = (err * gain) >>> 8;
        end else begin
          err = longint'(target_pos[j]) - meas;
          gain = longint'({48'd0, normal_gains[16*j +: 16]});
          acc = ((err * gain) >>> 8) + longint'(target_vel[j]);
        end
        if (acc > DriveMax) acc = DriveMax;
        else if (acc < DriveMin) acc = DriveMin;
        r.drive_velocity = acc[31:0];
      end
      r.holding = timeout_now;
      if (b.last) was_holding = timeout_now;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gains = '0;
      safe_gains = '0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        target_pos[i] = '0;
        target_vel[i] = '0;
        staged_pos[i] = '0;
        staged_vel[i] = '0;
        held_pos[i] = '0;
      end
      active_timeout = '0;
      staged_timeout = '0;
      staged_mask = '0;
      stopwatch = '0;
      was_holding = 1'b0;
      timeout_now = 1'b0;
      pending_drive_beats.delete();
      pending_o <= 0;
      fail_count_o <= fail_count;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          jvff_pkg::CFG_NORMAL_GAINS: normal_gains = cfg_i.wdata;
          jvff_pkg::CFG_SAFE_GAINS:   safe_gains = cfg_i.wdata;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        pending_drive_beats = {pending_drive_beats, next_drive_beat(req_i.data)};
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.data;
        if (pending_drive_beats.size() == 0) begin
          report_mismatch($sformatf("result beat for joint %0d with nothing outstanding",
                                    got.joint_out));
        end else begin
          want = pending_drive_beats.pop_front();
          if (got.status !== want.status) begin
            report_mismatch($sformatf("joint %0d status: got %0d, want %0d",
                                      want.joint_out, got.status, want.status));
          end
          if (got.joint_out !== want.joint_out) begin
            report_mismatch($sformatf("joint_out: got %0d, want %0d",
                                      got.joint_out, want.joint_out));
          end
          if (got.drive_velocity !== want.drive_velocity) begin
            report_mismatch($sformatf("joint %0d drive_velocity: got %0d, want %0d",
                                      want.joint_out, got.drive_velocity,
                                      want.drive_velocity));
          end
          if (got.holding !== want.holding) begin
            report_mismatch($sformatf("joint %0d holding: got %0b, want %0b",
                                      want.joint_out, got.holding, want.holding));
          end
        end
      end
      pending_o <= pending_drive_beats.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

@@ tb/sv/joint_velocity_ff_with_timeout_hold_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_velocity_ff_with_timeout_hold_tb
// Drives command and update groups into the joint velocity controller: a
// directed opening for extremes, hold, commit, reject and stopwatch cases,
// then randomized groups under several gain settings with random gaps and
// result stalls. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module joint_velocity_ff_with_timeout_hold_tb;

  localparam int unsigned NumJoints   = 4;
  localparam int unsigned RandomBeats = 600;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned CycleLimit  = 200000;
  localparam logic [31:0] PosMax      = 32'h7FFF_FFFF;
  localparam logic [31:0] PosMin      = 32'h8000_0000;

  logic        clk;
  logic        rst_n;
  bit          quiet = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned results_pending;

  jvff_req_if req_bus ();
  jvff_rsp_if rsp_bus ();
  jvff_cfg_if cfg_bus ();

  joint_velocity_ff_with_timeout_hold #(
    .NUM_JOINTS(NumJoints)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  jvff_drive_checker #(
    .NUM_JOINTS(NumJoints)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .cfg_i       (cfg_bus),
    .fail_count_o(fail_count),
    .pending_o   (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? PosMax : PosMin;
      1, 2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_timeout();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return '0;
    else if (pick < 8) return $urandom | 32'h8000_0000;
    else if (pick < 15) return 32'($urandom_range(1, 60));
    else if (pick < 18) return $urandom & PosMax;
    else return PosMax;
  endfunction

  function automatic logic [31:0] rand_elapsed();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) return 32'($urandom_range(0, 15));
    else if (pick < 18) return $urandom;
    else return '1;
  endfunction

  function automatic jvff_pkg::req_t cmd_beat(input logic [1:0] j, input logic [31:0] pos,
                                              input logic [31:0] ff,
                                              input logic [31:0] tmo, input bit last);
    jvff_pkg::req_t b;
    b.req_type      = jvff_pkg::REQ_CMD;
    b.joint         = j;
    b.position      = pos;
    b.ff_velocity   = ff;
    b.timeout_ticks = tmo;
    b.elapsed_ticks = $urandom;
    b.last          = last;
    return b;
  endfunction

  function automatic jvff_pkg::req_t upd_beat(input logic [1:0] j, input logic [31:0] pos,
                                              input logic [31:0] elapsed, input bit last);
    jvff_pkg::req_t b;
    b.req_type      = jvff_pkg::REQ_UPD;
    b.joint         = j;
    b.position      = pos;
    b.ff_velocity   = $urandom;
    b.timeout_ticks = $urandom;
    b.elapsed_ticks = elapsed;
    b.last          = last;
    return b;
  endfunction

  task automatic send_beat(input jvff_pkg::req_t beat);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= beat;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gains(input logic [jvff_pkg::GainsW-1:0] normal,
                             input logic [jvff_pkg::GainsW-1:0] safe);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= jvff_pkg::CFG_NORMAL_GAINS;
    cfg_bus.wdata <= normal;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.index <= jvff_pkg::CFG_SAFE_GAINS;
    cfg_bus.wdata <= safe;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_cmd_group(input bit broken);
    int unsigned order[$];
    int unsigned n;
    bit          open_end;
    order = {0, 1, 2, 3};
    order.shuffle();
    open_end = 1'b0;
    if (broken) begin
      case ($urandom_range(0, 2))
        0: order = order[0:$urandom_range(0, NumJoints - 2)];
        1: order = {order, order[$urandom_range(0, NumJoints - 1)]};
        default: open_end = 1'b1;
      endcase
    end
    n = order.size();
    for (int unsigned k = 0; k < n; k++) begin
      send_beat(cmd_beat(2'(order[k]), rand_q16(), rand_q16(), rand_timeout(),
                         (k == n - 1) && !open_end));
    end
  endtask

  task automatic send_upd_group();
    int unsigned order[$];
    int unsigned n;
    bit          open_end;
    order = {1, 2, 3};
    order.shuffle();
    if ($urandom_range(0, 9) != 0) order.push_front(0);
    else order = order[0:$urandom_range(0, 2)];
    open_end = ($urandom_range(0, 9) == 0);
    n = order.size();
    for (int unsigned k = 0; k < n; k++) begin
      send_beat(upd_beat(2'(order[k]), rand_q16(), rand_elapsed(),
                         (k == n - 1) && !open_end));
    end
  endtask

  task automatic send_noise();
    jvff_pkg::req_t b;
    repeat ($urandom_range(1, 4)) begin
      b.req_type      = jvff_pkg::req_e'($urandom_range(0, 1));
      b.joint         = 2'($urandom_range(0, 3));
      b.position      = $urandom;
      b.ff_velocity   = $urandom;
      b.timeout_ticks = $urandom;
      b.elapsed_ticks = $urandom;
      b.last          = 1'($urandom_range(0, 1));
      send_beat(b);
    end
  endtask

  initial begin
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned goal;
    int unsigned pick;
    bit          paused;
    paused = 1'b0;
    rst_n         <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= jvff_pkg::CFG_NORMAL_GAINS;
    cfg_bus.wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_gains(64'hFFFF_0100_0080_0001, 64'h0001_0080_0100_FFFF);

    // reset timeout is immediate, so positions latch and hold
    send_beat(upd_beat(2'd0, PosMax, 32'd0, 1'b0));
    send_beat(upd_beat(2'd1, PosMin, 32'd0, 1'b0));
    send_beat(upd_beat(2'd2, 32'd0, 32'd0, 1'b0));
    send_beat(upd_beat(2'd3, '1, 32'd0, 1'b1));
    // held positions frozen, large errors saturate
    send_beat(upd_beat(2'd0, PosMin, 32'd5, 1'b0));
    send_beat(upd_beat(2'd1, PosMax, 32'd0, 1'b0));
    send_beat(upd_beat(2'd2, 32'h0001_0000, 32'd0, 1'b0));
    send_beat(upd_beat(2'd3, PosMax, 32'd0, 1'b1));
    // full group commits, most negative timeout never expires
    send_beat(cmd_beat(2'd2, PosMin, PosMax, '1, 1'b0));
    send_beat(cmd_beat(2'd0, PosMax, PosMin, '1, 1'b0));
    send_beat(cmd_beat(2'd3, 32'd0, PosMax, '1, 1'b0));
    send_beat(cmd_beat(2'd1, 32'd1, PosMin, PosMin, 1'b1));
    // feed-forward drive saturating both ways
    send_beat(upd_beat(2'd0, PosMin, '1, 1'b0));
    send_beat(upd_beat(2'd1, PosMax, 32'd0, 1'b0));
    send_beat(upd_beat(2'd2, PosMax, 32'd0, 1'b0));
    send_beat(upd_beat(2'd3, PosMin, 32'd0, 1'b1));
    // incomplete group is rejected
    send_beat(cmd_beat(2'd0, 32'h0002_0000, 32'd7, 32'd3, 1'b0));
    send_beat(cmd_beat(2'd1, 32'h0003_0000, 32'd9, 32'd3, 1'b1));
    // timeout of the last staged beat wins
    send_beat(cmd_beat(2'd0, 32'h0001_0000, 32'h0000_8000, 32'd0, 1'b0));
    send_beat(cmd_beat(2'd1, 32'hFFFF_0000, 32'h0000_0100, 32'hFFFF_FFFB, 1'b0));
    send_beat(cmd_beat(2'd2, 32'h0000_4000, 32'hFFFF_8000, PosMax, 1'b0));
    send_beat(cmd_beat(2'd3, 32'h0010_0000, 32'd0, 32'd5, 1'b1));
    // group without joint 0 keeps the previous decision
    send_beat(upd_beat(2'd2, 32'h0000_2000, 32'd0, 1'b1));
    // stopwatch runs past the limit
    send_beat(upd_beat(2'd0, 32'h0000_1000, '1, 1'b1));

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p)
        0: write_gains('1, '0);
        1: write_gains('0, '1);
        3: write_gains({4{16'h0100}}, {$urandom, $urandom});
        default: write_gains({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      goal = beats_sent + RandomBeats / NumPhases;
      while (beats_sent < goal) begin
        quiet = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 40) send_cmd_group(1'b0);
        else if (pick < 80) send_upd_group();
        else if (pick < 90) send_cmd_group(1'b1);
        else send_noise();
        if ($urandom_range(0, 24) == 0 || (p == 2 && !paused)) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
